[design/error_event_ring_log_top_assert.svh]
// Assertion macros for the error event ring log top level.
`ifndef ERROR_EVENT_RING_LOG_TOP_ASSERT_SVH
`define ERROR_EVENT_RING_LOG_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ERL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("error_event_ring_log: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ERL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("error_event_ring_log: next-cycle check failed");

`endif

[design/erl_pkg.sv]
// Shared types and constants for the error event ring log.
package erl_pkg;

  // Default number of records in the ring.
  localparam int LOG_DEPTH_DEF = 64;

  // Most results a single walk may return, and the width of the request field.
  localparam int WALK_LIMIT = 64;
  localparam int WALK_W     = 7;

  // Action codes of an input item.
  localparam logic [1:0] ACT_POST    = 2'd0;
  localparam logic [1:0] ACT_WALK    = 2'd1;
  localparam logic [1:0] ACT_DIAG    = 2'd2;
  localparam logic [1:0] ACT_SUSPECT = 2'd3;

  // One stored error record.
  typedef struct packed {
    logic [7:0]  cls;
    logic [7:0]  severity;
    logic [7:0]  cpu;
    logic [63:0] target;
    logic [63:0] aux_a;
    logic [63:0] aux_b;
    logic [63:0] stamp;
  } rec_t;

  // Walk sequencer states.
  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_t;

endpackage

[design/error_event_ring_log_top.sv]
// Top level of the error event ring log: record memory, counters and walk sequencer.
//
//   Channel | Handshake                   | Contents
//   --------+-----------------------------+------------------------------------------
//   input   | in_valid / in_stall         | action, record fields, walk_max
//   output  | out_valid / out_stall       | entry_valid, last, record fields, counters
//
// A post, diagnosis note or suspect note gives no result.
// A walk gives min(walk_max, records held, 64) results, one per cycle while the output
// is not stalled, or one empty result; the input is stalled until the walk ends, with one
// read of the single read port of the record memory per record returned. Reset clears the
// counters and the sequencer; the record memory is not cleared. A stalled output holds
// its result and the walk waits on it.
module error_event_ring_log_top #(
  parameter int LOG_DEPTH = erl_pkg::LOG_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                action,
  input  logic [7:0]                in_class,
  input  logic [7:0]                in_severity,
  input  logic [7:0]                in_cpu,
  input  logic [63:0]               in_target,
  input  logic [63:0]               in_aux_a,
  input  logic [63:0]               in_aux_b,
  input  logic [63:0]               in_time,
  input  logic [erl_pkg::WALK_W-1:0] walk_max,
  // Output channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      entry_valid,
  output logic                      last,
  output logic [7:0]                out_class,
  output logic [7:0]                out_severity,
  output logic [7:0]                out_cpu,
  output logic [63:0]               out_target,
  output logic [63:0]               out_aux_a,
  output logic [63:0]               out_aux_b,
  output logic [63:0]               out_time,
  output logic [63:0]               records_posted,
  output logic [63:0]               diag_runs,
  output logic [63:0]               suspects_total
);

  `include "error_event_ring_log_top_assert.svh"

  localparam int IDX_W  = $clog2(LOG_DEPTH);
  localparam int HELD_W = $clog2(LOG_DEPTH + 1);
  localparam int WALK_W = erl_pkg::WALK_W;
  localparam int CMP_W  = (HELD_W > WALK_W) ? HELD_W : WALK_W;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(LOG_DEPTH - 1);
  localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(LOG_DEPTH);
  localparam logic [CMP_W-1:0]  WALK_CAP  = CMP_W'(erl_pkg::WALK_LIMIT);

  // Record memory.
  erl_pkg::rec_t ring_mem [LOG_DEPTH];
  erl_pkg::rec_t rd_rec;

  // Counters and ring bookkeeping.
  logic [63:0]       post_count;
  logic [63:0]       diagnosis_count;
  logic [63:0]       suspect_count;
  logic [IDX_W-1:0]  head;
  logic [HELD_W-1:0] held;

  // Walk sequencer.
  erl_pkg::walk_state_t state, state_next;
  logic [IDX_W-1:0]  rd_ptr;
  logic [WALK_W-1:0] remain;
  logic              walk_empty;

  // Output registers.
  logic              out_entry;
  logic              out_last;
  logic [63:0]       out_events;
  logic [63:0]       out_diag;
  logic [63:0]       out_susp;

  logic              in_take;
  logic              take_post;
  logic              take_walk;
  logic              issue;
  logic              issue_last;
  logic [CMP_W-1:0]  req_ext;
  logic [CMP_W-1:0]  held_ext;
  logic [CMP_W-1:0]  walk_n;
  logic [IDX_W-1:0]  newest;
  erl_pkg::rec_t     wr_rec;

  // Input handshake decode.
  assign in_take   = in_valid && !in_stall;
  assign take_post = in_take && (action == erl_pkg::ACT_POST);
  assign take_walk = in_take && (action == erl_pkg::ACT_WALK);

  // Walk length: request clamped to the records held and to the result limit.
  always_comb begin
    req_ext  = CMP_W'(walk_max);
    held_ext = CMP_W'(held);
    walk_n   = (req_ext < held_ext) ? req_ext : held_ext;
    if (walk_n > WALK_CAP) begin
      walk_n = WALK_CAP;
    end
  end

  assign newest = (head == '0) ? LAST_IDX : head - 1'b1;

  // Next state of the walk sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      erl_pkg::WALK_IDLE: begin
        if (take_walk) begin
          state_next = erl_pkg::WALK_RUN;
        end
      end
      erl_pkg::WALK_RUN: begin
        if (issue && issue_last) begin
          state_next = erl_pkg::WALK_IDLE;
        end
      end
      default: state_next = erl_pkg::WALK_IDLE;
    endcase
  end

  // Sequencer outputs: input stall and result issue.
  always_comb begin
    in_stall   = 1'b0;
    issue      = 1'b0;
    issue_last = walk_empty || (remain == WALK_W'(1));
    unique case (state)
      erl_pkg::WALK_IDLE: begin
        in_stall = 1'b0;
      end
      erl_pkg::WALK_RUN: begin
        in_stall = 1'b1;
        issue    = !out_valid || !out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erl_pkg::WALK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk pointer and count: newest record first, stepping back around the ring.
  always_ff @(posedge clk) begin
    if (take_walk) begin
      rd_ptr     <= newest;
      remain     <= WALK_W'(walk_n);
      walk_empty <= (walk_n == '0);
    end else if (issue) begin
      rd_ptr <= (rd_ptr == '0) ? LAST_IDX : rd_ptr - 1'b1;
      remain <= remain - 1'b1;
    end
  end

  // Counters; head and held restart when the post count wraps to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      post_count      <= '0;
      diagnosis_count <= '0;
      suspect_count   <= '0;
      head            <= '0;
      held            <= '0;
    end else if (in_take) begin
      case (action)
        erl_pkg::ACT_POST: begin
          post_count <= post_count + 64'd1;
          if (post_count == '1) begin
            head <= '0;
            held <= '0;
          end else begin
            head <= (head == LAST_IDX) ? '0 : head + 1'b1;
            if (held != HELD_FULL) begin
              held <= held + 1'b1;
            end
          end
        end
        erl_pkg::ACT_DIAG:    diagnosis_count <= diagnosis_count + 64'd1;
        erl_pkg::ACT_SUSPECT: suspect_count   <= suspect_count + 64'd1;
        default: ;
      endcase
    end
  end

  // Record memory: write at head on a post, registered read during a walk.
  always_comb begin
    wr_rec.cls      = in_class;
    wr_rec.severity = in_severity;
    wr_rec.cpu      = in_cpu;
    wr_rec.target   = in_target;
    wr_rec.aux_a    = in_aux_a;
    wr_rec.aux_b    = in_aux_b;
    wr_rec.stamp    = in_time;
  end

  always_ff @(posedge clk) begin
    if (take_post) begin
      ring_mem[head] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && !walk_empty) begin
      rd_rec <= ring_mem[rd_ptr];
    end
  end

  // Output register: loaded on issue, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_entry  <= !walk_empty;
      out_last   <= issue_last;
      out_events <= post_count;
      out_diag   <= diagnosis_count;
      out_susp   <= suspect_count;
    end
  end

  // Result fields; an empty result shows zero record fields.
  assign entry_valid     = out_entry;
  assign last            = out_last;
  assign out_class       = out_entry ? rd_rec.cls      : '0;
  assign out_severity    = out_entry ? rd_rec.severity : '0;
  assign out_cpu         = out_entry ? rd_rec.cpu      : '0;
  assign out_target      = out_entry ? rd_rec.target   : '0;
  assign out_aux_a       = out_entry ? rd_rec.aux_a    : '0;
  assign out_aux_b       = out_entry ? rd_rec.aux_b    : '0;
  assign out_time        = out_entry ? rd_rec.stamp    : '0;
  assign records_posted  = out_events;
  assign diag_runs       = out_diag;
  assign suspects_total  = out_susp;

  // An empty walk result is always the final one.
  `ERL_ASSERT_NOW(a_empty_is_last, clk, rst, out_valid && !out_entry, out_last)
  // A returned record implies at least one post.
  `ERL_ASSERT_NOW(a_entry_needs_post, clk, rst, out_valid && out_entry, out_events != '0)
  // Until the ring fills, head follows the post count.
  `ERL_ASSERT_NOW(a_head_tracks, clk, rst, held != HELD_FULL, head == IDX_W'(post_count))

endmodule
